### design/trapezoid_ramp_envelope_core_assert.svh
// Assertion macros for the trapezoid ramp envelope core.
// Expect clk and rst_n in the scope where a macro is used.
`ifndef TRAPEZOID_RAMP_ENVELOPE_CORE_ASSERT_SVH
`define TRAPEZOID_RAMP_ENVELOPE_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TRENV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TRENV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/trenv_pkg.sv
// Shared constants, codes and types of the trapezoid ramp envelope core.
// No dependencies; every other file but the assert header imports it.
package trenv_pkg;

  localparam int COUNT_BITS      = 20;
  localparam int LEVEL_FRAC_BITS = 16;

  localparam int LEVEL_W   = LEVEL_FRAC_BITS + 1;
  localparam int PROD_W    = 2 * COUNT_BITS;
  localparam int DIV_W     = COUNT_BITS + 1;
  localparam int NUM_W     = (COUNT_BITS > LEVEL_W) ? COUNT_BITS : LEVEL_W;
  localparam int ITER_W    = $clog2(NUM_W + 1);
  localparam int MUL_CNT_W = $clog2(COUNT_BITS);
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = '0;

  localparam logic [ACT_W-1:0] ACT_TICK       = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START      = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_UP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DOWN = 1'd1;

  typedef enum logic [1:0] {
    STAGE_UP   = 2'd0,
    STAGE_HOLD = 2'd1,
    STAGE_DOWN = 2'd2
  } stage_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DSPLIT,
    ST_DUP,
    ST_WUP,
    ST_DDN,
    ST_WDN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic                  start;
    logic [COUNT_BITS-1:0] mcand;
    logic [COUNT_BITS-1:0] mplier;
  } mul_cmd_t;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
    logic [DIV_W-1:0]  rem_init;
    logic [NUM_W-1:0]  num_init;
    logic [DIV_W-1:0]  divisor;
  } div_cmd_t;

endpackage

### design/trenv_if.sv
// Handshake channels of the envelope core: start/tick words in, level words out.
// Depends on trenv_pkg for field widths.
interface trenv_in_if import trenv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ACT_W-1:0]      action;
  logic [COUNT_BITS-1:0] duration_steps;
  logic [COUNT_BITS-1:0] up_steps;
  logic [COUNT_BITS-1:0] down_steps;

  modport source (output valid, action, duration_steps, up_steps, down_steps,
                  input ready);
  modport sink   (input valid, action, duration_steps, up_steps, down_steps,
                  output ready);
endinterface

interface trenv_out_if import trenv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic               running;
  logic [1:0]         stage;

  modport source (output valid, level, running, stage, input ready);
  modport sink   (input valid, level, running, stage, output ready);
endinterface

### design/trenv_serial_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on trenv_pkg.
module trenv_serial_mul import trenv_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  mul_cmd_t            cmd,
  output unit_stat_t          stat,
  output logic [PROD_W-1:0]   product
);

  logic                  busy_r;
  logic                  done_r;
  logic [MUL_CNT_W-1:0]  cnt_r;
  logic [COUNT_BITS-1:0] mcand_r;
  logic [PROD_W-1:0]     prod_r;
  logic [COUNT_BITS:0]   hi_sum;
  logic [PROD_W-1:0]     prod_nxt;

  // add the multiplicand into the high half on a set bit, then shift right
  always_comb begin
    hi_sum   = {1'b0, prod_r[PROD_W-1:COUNT_BITS]} +
               (prod_r[0] ? {1'b0, mcand_r} : {(COUNT_BITS+1){1'b0}});
    prod_nxt = {hi_sum, prod_r[COUNT_BITS-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(COUNT_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mcand_r <= cmd.mcand;
      prod_r  <= {{COUNT_BITS{1'b0}}, cmd.mplier};
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = prod_r;

endmodule

### design/trenv_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// Depends on trenv_pkg; shared by the length split and both ramp slopes.
module trenv_serial_div import trenv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_cmd_t          cmd,
  output unit_stat_t        stat,
  output logic [NUM_W-1:0]  quotient
);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] cnt_r;
  logic [ITER_W-1:0] iters_r;
  logic [DIV_W-1:0]  rem_r;
  logic [NUM_W-1:0]  num_r;
  logic [DIV_W-1:0]  dvs_r;
  logic [DIV_W:0]    rem2;
  logic [DIV_W:0]    diff;
  logic              ge;
  logic [DIV_W-1:0]  rem_nxt;
  logic [NUM_W-1:0]  num_nxt;

  // dividend bits leave at the top of num_r, quotient bits enter at the bottom
  always_comb begin
    rem2    = {rem_r, num_r[NUM_W-1]};
    ge      = (rem2 >= {1'b0, dvs_r});
    diff    = rem2 - {1'b0, dvs_r};
    rem_nxt = ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
    num_nxt = {num_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == iters_r - 1'b1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      iters_r <= cmd.iters;
      rem_r   <= cmd.rem_init;
      num_r   <= cmd.num_init;
      dvs_r   <= cmd.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = num_r;

endmodule

### design/trapezoid_ramp_envelope_core.sv
// Trapezoidal ramp envelope: a tick word advances the ramp-up, hold or ramp-down
// phase and is answered one word per cycle while the output is not stalled; a start word
// recomputes the phase lengths and slopes through a bit-serial multiplier and one shared
// bit-serial divider, first splitting the duration when it is shorter than the two ramps,
// and no further word is taken until its result is formed. Every word in gives exactly one
// word out: the level (Q16, 65536 is full scale), the running flag and the stage after it.
// A finished word waits in an output register while the next input is taken.
// Depends on trenv_pkg, trenv_if, trenv_serial_mul, trenv_serial_div and the assert header.
`include "trapezoid_ramp_envelope_core_assert.svh"

module trapezoid_ramp_envelope_core import trenv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COUNT_BITS-1:0] cfg_wdata,
  trenv_in_if.sink              in_ch,
  trenv_out_if.source           out_ch
);

  state_t state_r, state_nxt;

  logic                  res_pend_r;
  logic                  out_valid_r;
  logic [LEVEL_W-1:0]    out_level_r;
  logic                  out_running_r;
  stage_t                out_stage_r;

  logic [COUNT_BITS-1:0] latched_up_r;
  logic [COUNT_BITS-1:0] latched_down_r;
  logic [COUNT_BITS-1:0] dur_r;

  stage_t                stage_r;
  logic                  running_r;
  logic [LEVEL_W-1:0]    level_r;
  logic [LEVEL_W-1:0]    delta_r;
  logic [LEVEL_W-1:0]    delta_dn_r;
  logic [COUNT_BITS-1:0] tick_cnt_r;
  logic [COUNT_BITS-1:0] up_len_r;
  logic [COUNT_BITS-1:0] hold_len_r;
  logic [COUNT_BITS-1:0] down_len_r;
  logic                  endless_r;

  logic                  in_ready;
  logic                  in_acc;
  logic                  is_start;
  logic                  copy;
  logic                  div_wait;

  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS:0]   hold_diff;
  logic                  split_case;

  mul_cmd_t              mul_cmd;
  unit_stat_t            mul_stat;
  logic [PROD_W-1:0]     product;
  div_cmd_t              div_cmd;
  unit_stat_t            div_stat;
  logic [NUM_W-1:0]      div_q;
  logic [COUNT_BITS-1:0] q_split;
  logic [LEVEL_W-1:0]    q_delta;

  stage_t                stage_tk_nxt;
  logic                  running_tk_nxt;
  logic [LEVEL_W-1:0]    level_tk_nxt;
  logic [LEVEL_W-1:0]    delta_tk_nxt;
  logic [COUNT_BITS-1:0] cnt_tk_nxt;
  logic [LEVEL_W:0]      lvl_sum;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  go_down;

  trenv_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mul_cmd),
    .stat    (mul_stat),
    .product (product)
  );

  trenv_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign q_split = div_q[COUNT_BITS-1:0];
  assign q_delta = div_q[LEVEL_W-1:0];

  assign is_start = (in_ch.action == ACT_START) || (in_ch.action == ACT_LOAD_START);
  assign in_acc   = in_ch.valid && in_ready;
  assign copy     = res_pend_r && (!out_valid_r || out_ch.ready);
  assign div_wait = (state_r == ST_DSPLIT) || (state_r == ST_WUP) || (state_r == ST_WDN);

  assign sum        = {1'b0, latched_up_r} + {1'b0, latched_down_r};
  assign hold_diff  = {1'b0, dur_r} - sum;
  assign split_case = (dur_r != '0) && ({1'b0, dur_r} < sum);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc && is_start) state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = split_case ? ST_MUL : ST_DUP;
      ST_MUL:    if (mul_stat.done) state_nxt = ST_DSPLIT;
      ST_DSPLIT: if (div_stat.done) state_nxt = ST_DUP;
      ST_DUP:    state_nxt = (up_len_r != '0) ? ST_WUP : ST_DDN;
      ST_WUP:    if (div_stat.done) state_nxt = ST_DDN;
      ST_DDN:    state_nxt = (down_len_r != '0) ? ST_WDN : ST_FIN;
      ST_WDN:    if (div_stat.done) state_nxt = ST_FIN;
      ST_FIN:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs: input ready and unit commands
  always_comb begin
    in_ready         = 1'b0;
    mul_cmd.start    = 1'b0;
    mul_cmd.mcand    = dur_r;
    mul_cmd.mplier   = latched_up_r;
    div_cmd.start    = 1'b0;
    div_cmd.iters    = ITER_W'(LEVEL_W);
    div_cmd.rem_init = '0;
    div_cmd.num_init = NUM_W'(LEVEL_FULL) << (NUM_W - LEVEL_W);
    div_cmd.divisor  = {1'b0, up_len_r};
    case (state_r)
      ST_IDLE: begin
        in_ready = !res_pend_r || copy;
      end
      ST_SETUP: begin
        mul_cmd.start = split_case;
      end
      ST_MUL: begin
        // high product half is below the sum, so the quotient fits COUNT_BITS
        div_cmd.start    = mul_stat.done;
        div_cmd.iters    = ITER_W'(COUNT_BITS);
        div_cmd.rem_init = {1'b0, product[PROD_W-1:COUNT_BITS]};
        div_cmd.num_init = NUM_W'(product[COUNT_BITS-1:0]) << (NUM_W - COUNT_BITS);
        div_cmd.divisor  = sum;
      end
      ST_DUP: begin
        div_cmd.start = (up_len_r != '0);
      end
      ST_DDN: begin
        div_cmd.start   = (down_len_r != '0);
        div_cmd.divisor = {1'b0, down_len_r};
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // tick update of the running envelope
  always_comb begin
    stage_tk_nxt   = stage_r;
    running_tk_nxt = running_r;
    level_tk_nxt   = level_r;
    delta_tk_nxt   = delta_r;
    cnt_tk_nxt     = tick_cnt_r;
    go_down        = 1'b0;
    lvl_sum        = {1'b0, level_r} + {1'b0, delta_r};
    cnt_inc        = tick_cnt_r + 1'b1;
    if (running_r) begin
      case (stage_r)
        STAGE_UP: begin
          level_tk_nxt = (lvl_sum > {1'b0, LEVEL_FULL}) ? LEVEL_FULL : lvl_sum[LEVEL_W-1:0];
          cnt_tk_nxt   = cnt_inc;
          if (cnt_inc >= up_len_r) begin
            cnt_tk_nxt   = '0;
            level_tk_nxt = LEVEL_FULL;
            if (endless_r || (hold_len_r != '0)) stage_tk_nxt = STAGE_HOLD;
            else go_down = 1'b1;
          end
        end
        STAGE_HOLD: begin
          if (!endless_r) begin
            cnt_tk_nxt = cnt_inc;
            if (cnt_inc >= hold_len_r) go_down = 1'b1;
          end
        end
        default: begin
          level_tk_nxt = (level_r > delta_r) ? (level_r - delta_r) : LEVEL_ZERO;
          cnt_tk_nxt   = cnt_inc;
          if (cnt_inc >= down_len_r) begin
            level_tk_nxt   = LEVEL_ZERO;
            running_tk_nxt = 1'b0;
          end
        end
      endcase
      if (go_down) begin
        stage_tk_nxt = STAGE_DOWN;
        cnt_tk_nxt   = '0;
        if (down_len_r == '0) begin
          level_tk_nxt   = LEVEL_ZERO;
          running_tk_nxt = 1'b0;
        end else begin
          delta_tk_nxt = delta_dn_r;
        end
      end
    end
  end

  // control and envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      res_pend_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      latched_up_r   <= '0;
      latched_down_r <= '0;
      stage_r        <= STAGE_UP;
      running_r      <= 1'b0;
      level_r        <= '0;
      delta_r        <= '0;
      tick_cnt_r     <= '0;
      up_len_r       <= '0;
      hold_len_r     <= '0;
      down_len_r     <= '0;
      endless_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (copy) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_DEFAULT_UP:   latched_up_r   <= cfg_wdata;
          REG_DEFAULT_DOWN: latched_down_r <= cfg_wdata;
          default:          latched_up_r   <= latched_up_r;
        endcase
      end

      res_pend_r <= (res_pend_r && !copy) || (in_acc && !is_start) || (state_r == ST_FIN);

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.action == ACT_LOAD_START) begin
              latched_up_r   <= in_ch.up_steps;
              latched_down_r <= in_ch.down_steps;
            end
            if (!is_start) begin
              stage_r    <= stage_tk_nxt;
              running_r  <= running_tk_nxt;
              level_r    <= level_tk_nxt;
              delta_r    <= delta_tk_nxt;
              tick_cnt_r <= cnt_tk_nxt;
            end
          end
        end
        ST_SETUP: begin
          endless_r  <= (dur_r == '0);
          up_len_r   <= latched_up_r;
          down_len_r <= latched_down_r;
          if (dur_r == '0 || split_case) hold_len_r <= '0;
          else hold_len_r <= hold_diff[COUNT_BITS-1:0];
        end
        ST_DSPLIT: begin
          if (div_stat.done) begin
            up_len_r   <= q_split;
            down_len_r <= dur_r - q_split;
          end
        end
        ST_WUP: begin
          if (div_stat.done) delta_r <= q_delta;
        end
        ST_FIN: begin
          running_r  <= 1'b1;
          tick_cnt_r <= '0;
          if (up_len_r == '0) begin
            level_r <= LEVEL_FULL;
            if (endless_r || (hold_len_r != '0)) begin
              stage_r <= STAGE_HOLD;
            end else begin
              stage_r <= STAGE_DOWN;
              if (down_len_r == '0) begin
                level_r   <= LEVEL_ZERO;
                running_r <= 1'b0;
              end else begin
                delta_r <= delta_dn_r;
              end
            end
          end else begin
            stage_r <= STAGE_UP;
            level_r <= LEVEL_ZERO;
          end
        end
        default: begin
          endless_r <= endless_r;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc && is_start) dur_r <= in_ch.duration_steps;
    if (state_r == ST_WDN && div_stat.done) delta_dn_r <= q_delta;
    if (copy) begin
      out_level_r   <= level_r;
      out_running_r <= running_r;
      out_stage_r   <= stage_r;
    end
  end

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.level   = out_level_r;
  assign out_ch.running = out_running_r;
  assign out_ch.stage   = out_stage_r;

  `TRENV_ASSERT_IMP(a_mul_done_in_mul, mul_stat.done, state_r == ST_MUL, "mul done outside wait")
  `TRENV_ASSERT_IMP(a_div_done_in_wait, div_stat.done, div_wait, "div done outside wait")
  `TRENV_ASSERT_NXT(a_start_to_setup, in_acc && is_start, state_r == ST_SETUP, "start did not enter setup")
  `TRENV_ASSERT_NXT(a_idle_tick_holds, in_acc && !is_start && !running_r, $stable(level_r), "idle tick moved level")
  `TRENV_ASSERT_IMP(a_idle_units_quiet, state_r == ST_IDLE, !mul_stat.busy && !div_stat.busy, "unit busy while idle")

endmodule
